>>> rtl/core/fbsp_pkg.sv
`timescale 1ns / 1ps
// Five-bit symbol packer: shared constants, codes, types and bit-count helpers.
// Standalone package, no dependencies.
package fbsp_pkg;

    localparam int SYMBOL_COUNT = 27;
    localparam int CODE_BITS    = 5;
    localparam int WORD_BITS    = 16;

    localparam int SYM_W     = 5;
    localparam int CNT_W     = 16;
    localparam int ACT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int FWD_IDX_W = $clog2(SYMBOL_COUNT);
    localparam int REV_DEPTH = 1 << CODE_BITS;

    // holds the unpacked bits of a partial word plus one more code / word
    localparam int BUF_BITS = WORD_BITS + CODE_BITS - 1;
    localparam int FILL_W   = $clog2(BUF_BITS + 1);
    localparam int WONES_W  = $clog2(WORD_BITS + 1);
    localparam int CONES_W  = $clog2(CODE_BITS + 1);

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    // actions (s_axis_tuser)
    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ENC    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_END    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DSTART = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DWORD  = 3'd4;

    // result kinds (m_axis_tuser)
    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYM   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd3;

    typedef struct packed {
        logic                 wr_en;
        logic [SYM_W-1:0]     wr_sym;
        logic [CODE_BITS-1:0] wr_code;
        logic                 fwd_rd_en;
        logic [SYM_W-1:0]     fwd_rd_sym;
        logic                 rev_rd_en;
        logic [CODE_BITS-1:0] rev_rd_code;
    } t_tbl_req;

    function automatic logic [WONES_W-1:0] ones_word(input logic [WORD_BITS-1:0] v);
        logic [WONES_W-1:0] c;
        c = '0;
        for (int k = 0; k < WORD_BITS; k++) c = c + WONES_W'(v[k]);
        return c;
    endfunction

    function automatic logic [CONES_W-1:0] ones_code(input logic [CODE_BITS-1:0] v);
        logic [CONES_W-1:0] c;
        c = '0;
        for (int k = 0; k < CODE_BITS; k++) c = c + CONES_W'(v[k]);
        return c;
    endfunction

endpackage

>>> rtl/core/five_bit_symbol_packer.sv
`timescale 1ns / 1ps
// Five-bit symbol packer, top level. Depends on fbsp_pkg and fbsp_tables.
// Load: table write. Encode symbol: table read, then pack/emit.
// Encode end: padded-word slot, then summary. Decode word: reverse-table read, then
// beat for each symbol, then the check after the last expected symbol; one item is
// in flight at a time. Output register decouples m_axis_tready; a stall holds the
// sequencer in place.
// Synchronous active-low reset clears tables (valid bits), counters and buffers.
module five_bit_symbol_packer import fbsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // symbol[4:0], code_value[9:5], packed_word[25:10], expected_count[41:26],
    // expected_ones[57:42], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_word[15:0], out_symbol[20:16], total_symbols[36:21], total_ones[52:37],
    // check_ok[53], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENC  = 3'd1;
    localparam logic [2:0] ST_ENDW = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DRD  = 3'd4;
    localparam logic [2:0] ST_DOUT = 3'd5;
    localparam logic [2:0] ST_CHK  = 3'd6;

    localparam logic [CNT_W:0] OVERRUN = {1'b1, {CNT_W{1'b0}}};

    logic [2:0]             r_state, n_state;
    logic [BUF_BITS-1:0]    r_enc_bits, n_enc_bits;
    logic [FILL_W-1:0]      r_enc_fill, n_enc_fill;
    logic [CNT_W-1:0]       r_enc_symbols, n_enc_symbols;
    logic [CNT_W-1:0]       r_enc_ones, n_enc_ones;
    logic [BUF_BITS-1:0]    r_dec_bits, n_dec_bits;
    logic [FILL_W-1:0]      r_dec_fill, n_dec_fill;
    logic [CNT_W-1:0]       r_dec_remaining, n_dec_remaining;
    logic [CNT_W:0]         r_dec_ones_left, n_dec_ones_left;
    logic                   r_dec_last, n_dec_last;
    logic                   r_dec_chk, n_dec_chk;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [KIND_W-1:0]      r_m_kind;
    logic                   r_m_last;

    logic                   accept;
    logic                   can_push;
    logic                   push;
    logic [KIND_W-1:0]      push_kind;
    logic                   push_last;
    logic [WORD_BITS-1:0]   push_word;
    logic [SYM_W-1:0]       push_sym;
    logic [CNT_W-1:0]       push_tsym;
    logic [CNT_W-1:0]       push_tones;
    logic                   push_ok;

    t_tbl_req               tbl_req;
    logic [CODE_BITS-1:0]   fwd_code;
    logic [SYM_W-1:0]       rev_sym;

    logic [SYM_W-1:0]       in_sym;
    logic [CODE_BITS-1:0]   in_code;
    logic [WORD_BITS-1:0]   in_word;
    logic [CNT_W-1:0]       in_count;
    logic [CNT_W-1:0]       in_ones;
    logic                   sym_ok;

    logic [BUF_BITS-1:0]    enc_nb;
    logic [FILL_W-1:0]      enc_nf;
    logic [WORD_BITS-1:0]   enc_word;
    logic [WORD_BITS-1:0]   end_word;
    logic [WORD_BITS-1:0]   ones_src;
    logic [CNT_W:0]         ones_sum;
    logic [CNT_W-1:0]       ones_sat;
    logic [CODE_BITS-1:0]   dec_code;
    logic [CONES_W-1:0]     dec_p;
    logic [CNT_W-1:0]       dec_rem_m1;
    logic [FILL_W-1:0]      dec_fill_m;

    assign in_sym   = s_axis_tdata[4:0];
    assign in_code  = s_axis_tdata[9:5];
    assign in_word  = s_axis_tdata[25:10];
    assign in_count = s_axis_tdata[41:26];
    assign in_ones  = s_axis_tdata[57:42];
    assign sym_ok   = int'(in_sym) < SYMBOL_COUNT;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign can_push      = !r_m_valid || m_axis_tready;

    fbsp_tables u_tables (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_fwd_code (fwd_code),
        .o_rev_sym  (rev_sym)
    );

    // encode datapath: append one code, take the top word when 16 bits are buffered
    assign enc_nb   = BUF_BITS'({r_enc_bits, fwd_code});
    assign enc_nf   = r_enc_fill + FILL_W'(CODE_BITS);
    assign enc_word = WORD_BITS'(enc_nb >> (enc_nf - FILL_W'(WORD_BITS)));
    // left-justify the partial word, zero fill below
    assign end_word = WORD_BITS'(r_enc_bits << (FILL_W'(WORD_BITS) - r_enc_fill));
    assign ones_src = (r_state == ST_ENC) ? enc_word : end_word;
    assign ones_sum = {1'b0, r_enc_ones} + (CNT_W + 1)'(ones_word(ones_src));
    assign ones_sat = ones_sum[CNT_W] ? '1 : ones_sum[CNT_W-1:0];

    // decode datapath: oldest code sits just below the fill mark
    assign dec_code   = CODE_BITS'(r_dec_bits >> (r_dec_fill - FILL_W'(CODE_BITS)));
    assign dec_p      = ones_code(dec_code);
    assign dec_rem_m1 = r_dec_remaining - CNT_W'(1);
    assign dec_fill_m = r_dec_fill - FILL_W'(CODE_BITS);

    always_comb begin
        n_state         = r_state;
        n_enc_bits      = r_enc_bits;
        n_enc_fill      = r_enc_fill;
        n_enc_symbols   = r_enc_symbols;
        n_enc_ones      = r_enc_ones;
        n_dec_bits      = r_dec_bits;
        n_dec_fill      = r_dec_fill;
        n_dec_remaining = r_dec_remaining;
        n_dec_ones_left = r_dec_ones_left;
        n_dec_last      = r_dec_last;
        n_dec_chk       = r_dec_chk;

        tbl_req             = '0;
        tbl_req.wr_sym      = in_sym;
        tbl_req.wr_code     = in_code;
        tbl_req.fwd_rd_sym  = in_sym;
        tbl_req.rev_rd_code = dec_code;

        push       = 1'b0;
        push_kind  = KIND_WORD;
        push_last  = 1'b0;
        push_word  = '0;
        push_sym   = '0;
        push_tsym  = '0;
        push_tones = '0;
        push_ok    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_axis_tuser)
                        ACT_LOAD: begin
                            tbl_req.wr_en = sym_ok;
                        end
                        ACT_ENC: begin
                            if (sym_ok) begin
                                tbl_req.fwd_rd_en = 1'b1;
                                n_state           = ST_ENC;
                            end
                        end
                        ACT_END: begin
                            n_state = ST_ENDW;
                        end
                        ACT_DSTART: begin
                            n_dec_bits      = '0;
                            n_dec_fill      = '0;
                            n_dec_remaining = in_count;
                            n_dec_ones_left = {1'b0, in_ones};
                            if (in_count == '0) begin
                                n_state = ST_CHK;
                            end
                        end
                        ACT_DWORD: begin
                            if (r_dec_remaining != '0) begin
                                n_dec_bits = BUF_BITS'({r_dec_bits, in_word});
                                n_dec_fill = r_dec_fill + FILL_W'(WORD_BITS);
                                n_state    = ST_DRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENC: begin
                if (enc_nf >= FILL_W'(WORD_BITS)) begin
                    if (can_push) begin
                        push          = 1'b1;
                        push_kind     = KIND_WORD;
                        push_last     = 1'b1;
                        push_word     = enc_word;
                        n_enc_bits    = enc_nb;
                        n_enc_fill    = enc_nf - FILL_W'(WORD_BITS);
                        n_enc_ones    = ones_sat;
                        n_enc_symbols = (r_enc_symbols == '1) ? r_enc_symbols
                                                              : r_enc_symbols + CNT_W'(1);
                        n_state       = ST_IDLE;
                    end
                end else begin
                    n_enc_bits    = enc_nb;
                    n_enc_fill    = enc_nf;
                    n_enc_symbols = (r_enc_symbols == '1) ? r_enc_symbols
                                                          : r_enc_symbols + CNT_W'(1);
                    n_state       = ST_IDLE;
                end
            end
            ST_ENDW: begin
                if (r_enc_fill == '0) begin
                    n_state = ST_SUM;
                end else if (can_push) begin
                    push       = 1'b1;
                    push_kind  = KIND_WORD;
                    push_word  = end_word;
                    n_enc_ones = ones_sat;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                if (can_push) begin
                    push          = 1'b1;
                    push_kind     = KIND_SUM;
                    push_last     = 1'b1;
                    push_tsym     = r_enc_symbols;
                    push_tones    = r_enc_ones;
                    n_enc_bits    = '0;
                    n_enc_fill    = '0;
                    n_enc_symbols = '0;
                    n_enc_ones    = '0;
                    n_state       = ST_IDLE;
                end
            end
            ST_DRD: begin
                // here remaining > 0 and at least one whole code is buffered
                tbl_req.rev_rd_en = 1'b1;
                n_dec_fill        = dec_fill_m;
                n_dec_remaining   = dec_rem_m1;
                if (r_dec_ones_left[CNT_W] || ((CNT_W + 1)'(dec_p) > r_dec_ones_left)) begin
                    n_dec_ones_left = OVERRUN;
                end else begin
                    n_dec_ones_left = r_dec_ones_left - (CNT_W + 1)'(dec_p);
                end
                n_dec_chk  = (dec_rem_m1 == '0);
                n_dec_last = (dec_rem_m1 != '0) && (dec_fill_m < FILL_W'(CODE_BITS));
                n_state    = ST_DOUT;
            end
            ST_DOUT: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_kind = KIND_SYM;
                    push_last = r_dec_last;
                    push_sym  = rev_sym;
                    priority if (r_dec_chk) begin
                        n_state = ST_CHK;
                    end else if (r_dec_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DRD;
                    end
                end
            end
            ST_CHK: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_kind  = KIND_CHECK;
                    push_last  = 1'b1;
                    push_ok    = (r_dec_ones_left == '0);
                    n_dec_bits = '0;
                    n_dec_fill = '0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_enc_bits      <= '0;
            r_enc_fill      <= '0;
            r_enc_symbols   <= '0;
            r_enc_ones      <= '0;
            r_dec_bits      <= '0;
            r_dec_fill      <= '0;
            r_dec_remaining <= '0;
            r_dec_ones_left <= '0;
            r_dec_last      <= 1'b0;
            r_dec_chk       <= 1'b0;
            r_m_valid       <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_enc_bits      <= n_enc_bits;
            r_enc_fill      <= n_enc_fill;
            r_enc_symbols   <= n_enc_symbols;
            r_enc_ones      <= n_enc_ones;
            r_dec_bits      <= n_dec_bits;
            r_dec_fill      <= n_dec_fill;
            r_dec_remaining <= n_dec_remaining;
            r_dec_ones_left <= n_dec_ones_left;
            r_dec_last      <= n_dec_last;
            r_dec_chk       <= n_dec_chk;
            if (push) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_data <= {2'b00, push_ok, push_tones, push_tsym, push_sym, push_word};
            r_m_kind <= push_kind;
            r_m_last <= push_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

endmodule

>>> rtl/core/fbsp_tables.sv
`timescale 1ns / 1ps
// Forward (symbol -> code) and reverse (code -> symbol) tables, registered read.
// Depends on fbsp_pkg. Entries never written read as zero via per-entry valid bits.
module fbsp_tables import fbsp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tbl_req             i_req,
    output logic [CODE_BITS-1:0] o_fwd_code,
    output logic [SYM_W-1:0]     o_rev_sym
);

    logic [CODE_BITS-1:0]    r_fwd_mem [0:SYMBOL_COUNT-1];
    logic [SYM_W-1:0]        r_rev_mem [0:REV_DEPTH-1];
    logic [SYMBOL_COUNT-1:0] r_fwd_vld;
    logic [REV_DEPTH-1:0]    r_rev_vld;
    logic [CODE_BITS-1:0]    r_fwd_data;
    logic [SYM_W-1:0]        r_rev_data;
    logic                    r_fwd_hit;
    logic                    r_rev_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_fwd_mem[i_req.wr_sym[FWD_IDX_W-1:0]] <= i_req.wr_code;
            r_rev_mem[i_req.wr_code]               <= i_req.wr_sym;
        end
        if (i_req.fwd_rd_en) begin
            r_fwd_data <= r_fwd_mem[i_req.fwd_rd_sym[FWD_IDX_W-1:0]];
        end
        if (i_req.rev_rd_en) begin
            r_rev_data <= r_rev_mem[i_req.rev_rd_code];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= '0;
            r_rev_vld <= '0;
            r_fwd_hit <= 1'b0;
            r_rev_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_fwd_vld[i_req.wr_sym[FWD_IDX_W-1:0]] <= 1'b1;
                r_rev_vld[i_req.wr_code]               <= 1'b1;
            end
            if (i_req.fwd_rd_en) begin
                r_fwd_hit <= r_fwd_vld[i_req.fwd_rd_sym[FWD_IDX_W-1:0]];
            end
            if (i_req.rev_rd_en) begin
                r_rev_hit <= r_rev_vld[i_req.rev_rd_code];
            end
        end
    end

    assign o_fwd_code = r_fwd_hit ? r_fwd_data : '0;
    assign o_rev_sym  = r_rev_hit ? r_rev_data : '0;

endmodule
